// File: sv/tao_pkg.sv
`default_nettype none
package tao_pkg;

  localparam int SAMPLE_W  = 12;
  localparam int SUM_W     = 16;
  localparam int CNT_W     = 4;
  localparam int AVG_SHIFT = 4;
  localparam int AVG_W     = SUM_W - AVG_SHIFT;
  localparam int CFG_W     = 16;
  localparam int TEMP_W    = 16;
  localparam int NUM_CH    = 3;
  localparam int NUM_SUM   = 4;
  localparam int REF_IDX   = 3;
  localparam int CFG_IDX_W = 3;
  localparam int DIFF_W    = ((AVG_W + 1 > CFG_W) ? AVG_W + 1 : CFG_W) + 1;
  localparam int PROD_W    = DIFF_W + CFG_W;

  localparam logic [CNT_W-1:0] GROUP_LAST = '1;

  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_B = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_C = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_A   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_B   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_C   = 3'd5;

  typedef logic [SAMPLE_W-1:0]      sample_t;
  typedef logic [AVG_W-1:0]         avg_t;
  typedef logic signed [CFG_W-1:0]  cfg_t;
  typedef logic signed [TEMP_W-1:0] temp_t;

  typedef struct packed {
    sample_t sample_a;
    sample_t sample_b;
    sample_t sample_c;
    sample_t sample_ref;
  } in_word_t;

  typedef struct packed {
    temp_t temp_a;
    temp_t temp_b;
    temp_t temp_c;
    logic  present_a;
    logic  present_b;
    logic  present_c;
  } out_word_t;

  typedef struct packed {
    logic load;
    logic adv;
  } pipe_ctrl_t;

endpackage
`default_nettype wire

// File: sv/tao_accum.sv
`default_nettype none
module tao_accum
  import tao_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  input  wire in_word_t                 in_word,
  input  wire pipe_ctrl_t               ctrl,
  input  wire logic                     s2_free,
  output logic                          in_stall,
  output logic                          s1_v,
  output avg_t [NUM_SUM-1:0]            avg
);

  logic [SUM_W-1:0] sum_r   [NUM_SUM];
  logic [SUM_W-1:0] sum_nxt [NUM_SUM];
  sample_t          smp     [NUM_SUM];
  logic [CNT_W-1:0] cnt_r;
  logic             s1_v_r;
  avg_t [NUM_SUM-1:0] avg_r;
  logic             accept;
  logic             last;

  assign smp[0] = in_word.sample_a;
  assign smp[1] = in_word.sample_b;
  assign smp[2] = in_word.sample_c;
  assign smp[3] = in_word.sample_ref;

  always_comb begin
    for (int i = 0; i < NUM_SUM; i++) begin
      sum_nxt[i] = sum_r[i] + SUM_W'(smp[i]);
    end
  end

  // the closing word of a group needs a free average register
  assign in_stall = (cnt_r == GROUP_LAST) && s1_v_r && !s2_free;
  assign accept   = in_valid && !in_stall;
  assign last     = accept && (cnt_r == GROUP_LAST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SUM; i++) begin
        sum_r[i] <= '0;
      end
      cnt_r  <= '0;
      s1_v_r <= 1'b0;
    end else begin
      if (accept) begin
        if (last) begin
          for (int i = 0; i < NUM_SUM; i++) begin
            sum_r[i] <= '0;
          end
          cnt_r <= '0;
        end else begin
          for (int i = 0; i < NUM_SUM; i++) begin
            sum_r[i] <= sum_nxt[i];
          end
          cnt_r <= cnt_r + 1'b1;
        end
      end
      if (last) begin
        s1_v_r <= 1'b1;
      end else if (ctrl.load) begin
        s1_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (last) begin
      for (int i = 0; i < NUM_SUM; i++) begin
        avg_r[i] <= sum_nxt[i][SUM_W-1:AVG_SHIFT];
      end
    end
  end

  assign s1_v = s1_v_r;
  assign avg  = avg_r;

endmodule
`default_nettype wire

// File: sv/tao_lane.sv
`default_nettype none
module tao_lane
  import tao_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire pipe_ctrl_t ctrl,
  input  wire avg_t       avg,
  input  wire avg_t       ref_avg,
  input  wire cfg_t       offset,
  input  wire cfg_t       gain,
  output temp_t           temp,
  output logic            present
);

  localparam temp_t TEMP_MAX = {1'b0, {(TEMP_W-1){1'b1}}};
  localparam temp_t TEMP_MIN = {1'b1, {(TEMP_W-1){1'b0}}};

  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [PROD_W-1:0] prod_r;
  logic                     pres_r;
  temp_t                    last_r;
  temp_t                    sat;
  logic [PROD_W-TEMP_W:0]   hi;

  assign diff = DIFF_W'($signed({1'b0, avg})) - DIFF_W'($signed({1'b0, ref_avg}))
              - DIFF_W'(offset);
  assign prod_nxt = diff * gain;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      prod_r <= prod_nxt;
      pres_r <= (avg >= ref_avg);
    end
  end

  assign hi = prod_r[PROD_W-1:TEMP_W-1];

  always_comb begin
    if ((&hi) || !(|hi)) begin
      sat = prod_r[TEMP_W-1:0];
    end else if (prod_r[PROD_W-1]) begin
      sat = TEMP_MIN;
    end else begin
      sat = TEMP_MAX;
    end
  end

  // absent channel keeps its last value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= '0;
    end else if (ctrl.adv && pres_r) begin
      last_r <= sat;
    end
  end

  assign temp    = pres_r ? sat : last_r;
  assign present = pres_r;

endmodule
`default_nettype wire

// File: sv/tao_merge.sv
`default_nettype none
module tao_merge
  import tao_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    s1_v,
  input  wire temp_t [NUM_CH-1:0]      lane_temp,
  input  wire logic  [NUM_CH-1:0]      lane_present,
  input  wire logic                    out_stall,
  output pipe_ctrl_t                   ctrl,
  output logic                         s2_free,
  output logic                         out_valid,
  output out_word_t                    out_word
);

  logic      s2_v_r;
  logic      out_v_r;
  out_word_t out_word_r;
  logic      out_free;

  assign out_free  = !out_v_r || !out_stall;
  assign ctrl.adv  = s2_v_r && out_free;
  assign s2_free   = !s2_v_r || out_free;
  assign ctrl.load = s1_v && s2_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (ctrl.load) begin
        s2_v_r <= 1'b1;
      end else if (ctrl.adv) begin
        s2_v_r <= 1'b0;
      end
      if (ctrl.adv) begin
        out_v_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.adv) begin
      out_word_r.temp_a    <= lane_temp[0];
      out_word_r.temp_b    <= lane_temp[1];
      out_word_r.temp_c    <= lane_temp[2];
      out_word_r.present_a <= lane_present[0];
      out_word_r.present_b <= lane_present[1];
      out_word_r.present_c <= lane_present[2];
    end
  end

  assign out_valid = out_v_r;
  assign out_word  = out_word_r;

endmodule
`default_nettype wire

// File: sv/thermocouple_average_offset_top.sv
// the word closing a group of 16 passes the averaging, product and output registers
// throughput: one input word per cycle unless in_stall; one result per 16 input words
// the averaging register, the lane product registers and the output register
// hold work in flight; in_stall rises only on the closing word of a group when
// all are full and out_stall holds
// reset: synchronous, active low; clears sums, group count, last values,
// offsets to 0 and gains to 1
`default_nettype none
module thermocouple_average_offset_top
  import tao_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_word_t             in_word,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_word_t                 out_word,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  cfg_t [NUM_CH-1:0]   offset_r;
  cfg_t [NUM_CH-1:0]   gain_r;
  avg_t [NUM_SUM-1:0]  avg;
  temp_t [NUM_CH-1:0]  lane_temp;
  logic [NUM_CH-1:0]   lane_present;
  pipe_ctrl_t          ctrl;
  logic                s1_v;
  logic                s2_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CH; i++) begin
        offset_r[i] <= '0;
        gain_r[i]   <= cfg_t'(1);
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OFFSET_A: offset_r[0] <= cfg_wdata;
        REG_OFFSET_B: offset_r[1] <= cfg_wdata;
        REG_OFFSET_C: offset_r[2] <= cfg_wdata;
        REG_GAIN_A:   gain_r[0]   <= cfg_wdata;
        REG_GAIN_B:   gain_r[1]   <= cfg_wdata;
        REG_GAIN_C:   gain_r[2]   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  tao_accum u_accum (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_word  (in_word),
    .ctrl     (ctrl),
    .s2_free  (s2_free),
    .in_stall (in_stall),
    .s1_v     (s1_v),
    .avg      (avg)
  );

  for (genvar g = 0; g < NUM_CH; g++) begin : g_lane
    tao_lane u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (ctrl),
      .avg     (avg[g]),
      .ref_avg (avg[REF_IDX]),
      .offset  (offset_r[g]),
      .gain    (gain_r[g]),
      .temp    (lane_temp[g]),
      .present (lane_present[g])
    );
  end

  tao_merge u_merge (
    .clk          (clk),
    .rst_n        (rst_n),
    .s1_v         (s1_v),
    .lane_temp    (lane_temp),
    .lane_present (lane_present),
    .out_stall    (out_stall),
    .ctrl         (ctrl),
    .s2_free      (s2_free),
    .out_valid    (out_valid),
    .out_word     (out_word)
  );

endmodule
`default_nettype wire

// File: sv/tao_checker.sv
`default_nettype none
module tao_checker
  import tao_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_stall,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire out_word_t            out_word
);

  // reset empties the output stage
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid after reset");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled result word changed");

  // input backs up only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("in_stall without stalled output");

  // a rising result must follow an accepted input word
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 3))
    else $error("result without input");

endmodule

bind thermocouple_average_offset_top tao_checker u_chk (.*);
`default_nettype wire
